/* rtl/uv_sphere_vertex_generator_defines.svh */
// ---------------------------------------------------------------------------
// uv_sphere_vertex_generator_defines - assertion macros
// Shared property wrappers for the sphere vertex checker.
// ---------------------------------------------------------------------------
`ifndef UV_SPHERE_VERTEX_GENERATOR_DEFINES_SVH
`define UV_SPHERE_VERTEX_GENERATOR_DEFINES_SVH

// same-cycle implication, disabled in reset
`define SPHV_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled in reset
`define SPHV_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/sphv_pkg.sv */
// ---------------------------------------------------------------------------
// sphv_pkg - shared types, constants and functions
// Divider and CORDIC cell payloads, arctangent table, rounding helpers.
// ---------------------------------------------------------------------------
package sphv_pkg;

  typedef enum logic [2:0] {
    REG_RADIUS      = 3'd0,
    REG_WIDTH       = 3'd1,
    REG_HEIGHT      = 3'd2,
    REG_PHI_BEGIN   = 3'd3,
    REG_PHI_SPAN    = 3'd4,
    REG_THETA_BEGIN = 3'd5,
    REG_THETA_SPAN  = 3'd6
  } cfg_reg_t;

  // restoring divider lane: partial remainder, dividend bits / quotient bits, divisor
  typedef struct packed {
    logic [9:0]  rem;
    logic [16:0] low;
    logic [8:0]  d;
  } div_t;

  typedef struct packed {
    logic signed [33:0] x;
    logic signed [33:0] y;
    logic signed [33:0] z;
    logic [1:0]         quad;
  } cordic_t;

  typedef struct packed {
    logic [16:0] quad_base;
    logic        quad_valid;
    logic        top_line;
  } sideband_t;

  localparam logic [31:0] ATAN_Q30 [24] = '{
    32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76, 32'h01FFD55B,
    32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
    32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF, 32'h00003FFF, 32'h00001FFF,
    32'h00000FFF, 32'h000007FF, 32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F
  };

  localparam logic [33:0] CORDIC_X0  = 34'h026DD3B6A;  // gain compensation, Q2.30
  localparam logic [30:0] TWO_PI_Q28 = 31'd1686629713;

  localparam logic [16:0] FULL_TURN = 17'h10000;

  function automatic cordic_t cordic_init(input logic [15:0] ang);
    cordic_t     c;
    logic [44:0] prod;
    prod   = 45'(ang[13:0]) * 45'(TWO_PI_Q28);
    c.x    = $signed(CORDIC_X0);
    c.y    = '0;
    c.z    = $signed({3'b000, prod[44:14]});
    c.quad = ang[15:14];
    return c;
  endfunction

  function automatic logic signed [15:0] round_clamp14(input logic signed [34:0] v);
    logic signed [34:0] t;
    t = (v + 35'sd32768) >>> 16;
    if (t > 35'sd16384)
      return 16'sd16384;
    else if (t < -35'sd16384)
      return -16'sd16384;
    else
      return t[15:0];
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [49:0] v);
    if (v > 50'sd32767)
      return 16'sh7FFF;
    else if (v < -50'sd32768)
      return 16'sh8000;
    else
      return v[15:0];
  endfunction

endpackage

/* rtl/uv_sphere_vertex_generator.sv */
// Throughput: one beat per cycle; the whole chain advances together and
// holds only while the output beat is stalled.
// Depth is set by the 17-cell divider row and the CORDIC_STEPS-cell rotator row.
// Reset (rst, synchronous) empties the pipeline and loads register defaults.
// ---------------------------------------------------------------------------
// uv_sphere_vertex_generator - UV sphere vertex pipeline
// Grid point in; position, normal, texture coordinates and quad flags out.
// ---------------------------------------------------------------------------
module uv_sphere_vertex_generator #(
  parameter int MAX_SEGMENTS = 256,
  parameter int CORDIC_STEPS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [8:0]         ring_index,
  input  logic [8:0]         seg_index,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] pos_x,
  output logic signed [15:0] pos_y,
  output logic signed [15:0] pos_z,
  output logic signed [15:0] norm_x,
  output logic signed [15:0] norm_y,
  output logic signed [15:0] norm_z,
  output logic [16:0]        tex_u,
  output logic [16:0]        tex_v,
  output logic [16:0]        quad_base,
  output logic               quad_valid,
  output logic               top_line,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [16:0]        cfg_data
);
  import sphv_pkg::*;

  localparam int LAT     = CORDIC_STEPS + 23;
  localparam int TEX_DLY = CORDIC_STEPS + 5;

  logic [15:0] sphere_radius, phi_begin, theta_begin;
  logic [8:0]  width_count, height_count;
  logic [16:0] phi_span, theta_span;

  always_ff @(posedge clk) begin
    if (rst) begin
      sphere_radius <= 16'd256;
      width_count   <= 9'd32;
      height_count  <= 9'd16;
      phi_begin     <= 16'd0;
      phi_span      <= 17'h10000;
      theta_begin   <= 16'd0;
      theta_span    <= 17'h08000;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_RADIUS:      sphere_radius <= cfg_data[15:0];
        REG_WIDTH:       width_count   <= cfg_data[8:0];
        REG_HEIGHT:      height_count  <= cfg_data[8:0];
        REG_PHI_BEGIN:   phi_begin     <= cfg_data[15:0];
        REG_PHI_SPAN:    phi_span      <= cfg_data;
        REG_THETA_BEGIN: theta_begin   <= cfg_data[15:0];
        REG_THETA_SPAN:  theta_span    <= cfg_data;
        default: ;
      endcase
    end
  end

  logic en;
  logic [LAT-1:0] vld;

  assign en        = !(vld[LAT-1] && out_stall);
  assign in_stall  = !en;
  assign out_valid = vld[LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], in_valid};
    end
  end

  // input stage: clamp counts and indices, form dividends
  logic [8:0]  w_cnt, h_cnt, ring_c, seg_c;
  logic [16:0] tsp, psp;
  logic [25:0] prod_t, prod_p;
  logic [24:0] dvd [4];
  logic [18:0] base_full;
  sideband_t   sb_in, sb_out;
  div_t        div_init [4];

  always_comb begin
    w_cnt = width_count;
    if (width_count == 9'd0) w_cnt = 9'd1;
    else if (int'(width_count) > MAX_SEGMENTS) w_cnt = 9'(MAX_SEGMENTS);
    h_cnt = height_count;
    if (height_count == 9'd0) h_cnt = 9'd1;
    else if (int'(height_count) > MAX_SEGMENTS) h_cnt = 9'(MAX_SEGMENTS);
    ring_c = (ring_index > h_cnt) ? h_cnt : ring_index;
    seg_c  = (seg_index > w_cnt) ? w_cnt : seg_index;
    tsp    = (theta_span > FULL_TURN) ? FULL_TURN : theta_span;
    psp    = (phi_span > FULL_TURN) ? FULL_TURN : phi_span;
    prod_t = 26'(ring_c) * 26'(tsp);
    prod_p = 26'(seg_c) * 26'(psp);
    dvd[0] = prod_t[24:0];
    dvd[1] = prod_p[24:0];
    dvd[2] = {seg_c, 16'd0};
    dvd[3] = {ring_c, 16'd0};
    for (int l = 0; l < 4; l++) begin
      div_init[l].rem = {2'b00, dvd[l][24:17]};
      div_init[l].low = dvd[l][16:0];
      div_init[l].d   = (l == 1 || l == 2) ? w_cnt : h_cnt;
    end
    base_full        = 19'(ring_c) * 19'({1'b0, w_cnt} + 10'd1) + 19'(seg_c);
    sb_in.quad_base  = base_full[16:0];
    sb_in.quad_valid = (ring_c < h_cnt) && (seg_c < w_cnt);
    sb_in.top_line   = (ring_c < h_cnt) && (seg_c < w_cnt) && (ring_c == 9'd0);
  end

  div_t dv_in [4];
  div_t dv [18][4];

  always_ff @(posedge clk) begin
    if (en) dv_in <= div_init;
  end

  genvar s, l;
  generate
    for (l = 0; l < 4; l++) begin : g_div_lane
      assign dv[0][l] = dv_in[l];
      for (s = 0; s < 17; s++) begin : g_div_step
        sphv_div_cell u_cell (.clk(clk), .en(en), .din(dv[s][l]), .dout(dv[s+1][l]));
      end
    end
  endgenerate

  // angle stage feeding the two rotator rows (theta, phi)
  cordic_t cd_in [2];
  cordic_t cd [CORDIC_STEPS+1][2];

  always_ff @(posedge clk) begin
    if (en) begin
      cd_in[0] <= cordic_init(theta_begin + dv[17][0].low[15:0]);
      cd_in[1] <= cordic_init(phi_begin + dv[17][1].low[15:0]);
    end
  end

  generate
    for (l = 0; l < 2; l++) begin : g_cor_lane
      assign cd[0][l] = cd_in[l];
      for (s = 0; s < CORDIC_STEPS; s++) begin : g_cor_step
        sphv_cordic_cell #(.STEP(s)) u_cell (
          .clk(clk), .en(en), .din(cd[s][l]), .dout(cd[s+1][l])
        );
      end
    end
  endgenerate

  // quadrant fold and rounding to Q1.14
  logic signed [34:0] cx [2], sy [2];

  always_comb begin
    for (int k = 0; k < 2; k++) begin
      case (cd[CORDIC_STEPS][k].quad)
        2'd0: begin
          cx[k] = 35'(cd[CORDIC_STEPS][k].x);
          sy[k] = 35'(cd[CORDIC_STEPS][k].y);
        end
        2'd1: begin
          cx[k] = -35'(cd[CORDIC_STEPS][k].y);
          sy[k] = 35'(cd[CORDIC_STEPS][k].x);
        end
        2'd2: begin
          cx[k] = -35'(cd[CORDIC_STEPS][k].x);
          sy[k] = -35'(cd[CORDIC_STEPS][k].y);
        end
        default: begin
          cx[k] = 35'(cd[CORDIC_STEPS][k].y);
          sy[k] = -35'(cd[CORDIC_STEPS][k].x);
        end
      endcase
    end
  end

  logic signed [15:0] st, ct, sp, cp;

  always_ff @(posedge clk) begin
    if (en) begin
      st <= round_clamp14(sy[0]);
      ct <= round_clamp14(cx[0]);
      sp <= round_clamp14(sy[1]);
      cp <= round_clamp14(cx[1]);
    end
  end

  // first products
  logic signed [32:0] rst_p, rct_p;
  logic signed [31:0] stsp, stcp;
  logic signed [15:0] sp1, cp1, ct1;

  always_ff @(posedge clk) begin
    if (en) begin
      rst_p <= $signed({1'b0, sphere_radius}) * st;
      rct_p <= $signed({1'b0, sphere_radius}) * ct;
      stsp  <= st * sp;
      stcp  <= st * cp;
      sp1   <= sp;
      cp1   <= cp;
      ct1   <= ct;
    end
  end

  // second products, normal and y rounding
  logic signed [48:0] pxp, pzp;
  logic signed [15:0] py2, nx2, ny2, nz2;
  logic signed [32:0] rct_r, nx_r, nz_r;

  always_comb begin
    rct_r = (rct_p + 33'sd8192) >>> 14;
    nx_r  = (33'(stsp) + 33'sd8192) >>> 14;
    nz_r  = (33'(stcp) + 33'sd8192) >>> 14;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pxp <= rst_p * sp1;
      pzp <= rst_p * cp1;
      py2 <= sat16(50'(rct_r));
      nx2 <= 16'(-nx_r);
      ny2 <= ct1;
      nz2 <= 16'(-nz_r);
    end
  end

  // output register
  logic signed [49:0] px_r, pz_r;

  always_comb begin
    px_r = -((50'(pxp) + 50'sd134217728) >>> 28);
    pz_r = -((50'(pzp) + 50'sd134217728) >>> 28);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pos_x  <= sat16(px_r);
      pos_y  <= py2;
      pos_z  <= sat16(pz_r);
      norm_x <= nx2;
      norm_y <= ny2;
      norm_z <= nz2;
    end
  end

  // side data
  logic [33:0] tex_in, tex_out;

  assign tex_in = {dv[17][2].low, dv[17][3].low};

  sphv_delay #(.W(34), .DEPTH(TEX_DLY)) u_tex_dly (
    .clk(clk), .en(en), .din(tex_in), .dout(tex_out)
  );

  sphv_delay #(.W($bits(sideband_t)), .DEPTH(LAT)) u_sb_dly (
    .clk(clk), .en(en), .din(sb_in), .dout(sb_out)
  );

  assign tex_u      = tex_out[33:17];
  assign tex_v      = tex_out[16:0];
  assign quad_base  = sb_out.quad_base;
  assign quad_valid = sb_out.quad_valid;
  assign top_line   = sb_out.top_line;

endmodule

/* rtl/sphv_div_cell.sv */
// ---------------------------------------------------------------------------
// sphv_div_cell - one restoring division step
// Shifts in one dividend bit, subtracts the divisor when it fits, emits a quotient bit.
// ---------------------------------------------------------------------------
module sphv_div_cell (
  input  logic           clk,
  input  logic           en,
  input  sphv_pkg::div_t din,
  output sphv_pkg::div_t dout
);
  import sphv_pkg::*;

  logic [9:0] t;
  logic       ge;

  always_comb begin
    t  = {din.rem[8:0], din.low[16]};
    ge = (t >= {1'b0, din.d});
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dout.rem <= ge ? (t - {1'b0, din.d}) : t;
      dout.low <= {din.low[15:0], ge};
      dout.d   <= din.d;
    end
  end

endmodule

/* rtl/sphv_cordic_cell.sv */
// ---------------------------------------------------------------------------
// sphv_cordic_cell - one CORDIC rotation step
// Rotates toward zero residual angle by the arctangent of 2^-STEP.
// ---------------------------------------------------------------------------
module sphv_cordic_cell #(
  parameter int STEP = 0
) (
  input  logic              clk,
  input  logic              en,
  input  sphv_pkg::cordic_t din,
  output sphv_pkg::cordic_t dout
);
  import sphv_pkg::*;

  logic signed [33:0] dx, dy, at;

  always_comb begin
    dx = din.y >>> STEP;
    dy = din.x >>> STEP;
    at = $signed({2'b00, ATAN_Q30[STEP]});
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (!din.z[33]) begin
        dout.x <= din.x - dx;
        dout.y <= din.y + dy;
        dout.z <= din.z - at;
      end else begin
        dout.x <= din.x + dx;
        dout.y <= din.y - dy;
        dout.z <= din.z + at;
      end
      dout.quad <= din.quad;
    end
  end

endmodule

/* rtl/sphv_delay.sv */
// ---------------------------------------------------------------------------
// sphv_delay - enabled shift line
// Carries side data alongside the arithmetic stages.
// ---------------------------------------------------------------------------
module sphv_delay #(
  parameter int W     = 8,
  parameter int DEPTH = 1
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] din,
  output logic [W-1:0] dout
);
  import sphv_pkg::*;

  logic [W-1:0] taps [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      taps[0] <= din;
      for (int i = 1; i < DEPTH; i++) taps[i] <= taps[i-1];
    end
  end

  assign dout = taps[DEPTH-1];

endmodule

/* rtl/sphv_checker.sv */
// ---------------------------------------------------------------------------
// sphv_checker - port-level checks for the sphere vertex generator
// Watches the top-level ports and flags handshake and result inconsistencies.
// ---------------------------------------------------------------------------
`include "uv_sphere_vertex_generator_defines.svh"

module sphv_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic signed [15:0] pos_x,
  input logic signed [15:0] norm_y,
  input logic [16:0]        tex_u,
  input logic [16:0]        quad_base,
  input logic               quad_valid,
  input logic               top_line
);

  // a stalled result beat holds
  `SPHV_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(pos_x) && $stable(quad_base), "stalled result beat changed")

  // input backpressure only comes from a stalled full output
  `SPHV_ASSERT_NOW(a_in_stall_src, in_stall, out_valid && out_stall, "input stalled without output stall")

  `SPHV_ASSERT_NOW(a_top_line, out_valid && top_line, quad_valid, "top line without quad")

  `SPHV_ASSERT_NOW(a_tex_u_quad, out_valid && quad_valid, tex_u != 17'h10000, "tex_u at full turn on a quad")

  `SPHV_ASSERT_NOW(a_norm_y_rng, out_valid, (norm_y <= 16'sd16384) && (norm_y >= -16'sd16384), "norm_y out of range")

endmodule

bind uv_sphere_vertex_generator sphv_checker u_sphv_checker (.*);

/* tb/tb.sv */
// ---------------------------------------------------------------------------
// tb - UV sphere vertex generator testbench
// Streams grid points under several sphere settings, predicts each vertex
// with a local CORDIC model and checks every output beat in order.
// ---------------------------------------------------------------------------
module tb;
  import sphv_pkg::*;

  localparam int MAX_SEG = 256;
  localparam int STEPS   = 16;
  localparam int LATENCY = STEPS + 23;
  localparam int WATCHDOG_LIMIT = 2000;

  typedef struct packed {
    logic [15:0] px, py, pz, nx, ny, nz;
    logic [16:0] u, v, base;
    logic        qv, tl;
  } vertex_t;

  logic clk = 0, rst = 1;
  logic in_valid = 0, in_stall, out_valid, out_stall = 0;
  logic [8:0] ring_index = '0, seg_index = '0;
  logic signed [15:0] pos_x, pos_y, pos_z, norm_x, norm_y, norm_z;
  logic [16:0] tex_u, tex_v, quad_base;
  logic quad_valid, top_line;
  logic cfg_we = 0;
  logic [2:0] cfg_index = '0;
  logic [16:0] cfg_data = '0;

  uv_sphere_vertex_generator dut (.*);

  initial forever #5 clk = ~clk;

  // shadow registers
  longint radius, wcnt, hcnt, pbeg, pspan, tbeg, tspan;
  vertex_t expected_vertices[$];
  int errors = 0;
  int idle_cycles = 0;
  bit in_idle_en = 1, out_idle_en = 1;

  localparam longint ATAN [24] = '{
    64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76, 64'h01FFD55B,
    64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD, 64'h000FFFFF, 64'h0007FFFF,
    64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF, 64'h00007FFF, 64'h00003FFF, 64'h00001FFF,
    64'h00000FFF, 64'h000007FF, 64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F
  };

  function automatic longint rnd_shift(longint v, int s);
    return (v + (longint'(1) << (s - 1))) >>> s;
  endfunction

  function automatic longint clip(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic void turn_sincos(input longint ang, output longint s, output longint c);
    longint x, y, z, dx, dy, cc, ss;
    x = 64'h26DD3B6A;
    y = 0;
    z = ((ang & 16'h3FFF) * 64'd1686629713) >> 14;
    for (int i = 0; i < STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= ATAN[i];
      end else begin
        x += dx; y -= dy; z += ATAN[i];
      end
    end
    case ((ang >> 14) & 3)
      0: begin cc = x; ss = y; end
      1: begin cc = -y; ss = x; end
      2: begin cc = -x; ss = -y; end
      default: begin cc = y; ss = -x; end
    endcase
    c = clip(rnd_shift(cc, 16), -16384, 16384);
    s = clip(rnd_shift(ss, 16), -16384, 16384);
  endfunction

  function automatic vertex_t sphere_vertex(longint ring, longint seg);
    vertex_t e;
    longint w, h, ts, ps, th, ph, st, ct, sp, cp;
    w = clip(wcnt, 1, MAX_SEG);
    h = clip(hcnt, 1, MAX_SEG);
    ts = tspan > 65536 ? 65536 : tspan;
    ps = pspan > 65536 ? 65536 : pspan;
    if (ring > h) ring = h;
    if (seg > w) seg = w;
    th = (tbeg + ring * ts / h) & 16'hFFFF;
    ph = (pbeg + seg * ps / w) & 16'hFFFF;
    turn_sincos(th, st, ct);
    turn_sincos(ph, sp, cp);
    e.px = 16'(clip(-rnd_shift(radius * st * sp, 28), -32768, 32767));
    e.py = 16'(clip(rnd_shift(radius * ct, 14), -32768, 32767));
    e.pz = 16'(clip(-rnd_shift(radius * st * cp, 28), -32768, 32767));
    e.nx = 16'(-rnd_shift(st * sp, 14));
    e.ny = 16'(ct);
    e.nz = 16'(-rnd_shift(st * cp, 14));
    e.u = 17'((seg << 16) / w);
    e.v = 17'((ring << 16) / h);
    e.base = 17'(ring * (w + 1) + seg);
    e.qv = ring < h && seg < w;
    e.tl = e.qv && ring == 0;
    return e;
  endfunction

  task automatic write_reg(cfg_reg_t idx, longint val);
    @(negedge clk);
    cfg_we = 1;
    cfg_index = idx;
    cfg_data = 17'(val);
    case (idx)
      REG_RADIUS:      radius = val & 16'hFFFF;
      REG_WIDTH:       wcnt = val & 9'h1FF;
      REG_HEIGHT:      hcnt = val & 9'h1FF;
      REG_PHI_BEGIN:   pbeg = val & 16'hFFFF;
      REG_PHI_SPAN:    pspan = val & 17'h1FFFF;
      REG_THETA_BEGIN: tbeg = val & 16'hFFFF;
      REG_THETA_SPAN:  tspan = val & 17'h1FFFF;
      default: ;
    endcase
    @(negedge clk);
    cfg_we = 0;
  endtask

  task automatic configure(longint r, longint w, longint h, longint pb, longint ps,
                           longint tb_, longint ts);
    write_reg(REG_RADIUS, r);
    write_reg(REG_WIDTH, w);
    write_reg(REG_HEIGHT, h);
    write_reg(REG_PHI_BEGIN, pb);
    write_reg(REG_PHI_SPAN, ps);
    write_reg(REG_THETA_BEGIN, tb_);
    write_reg(REG_THETA_SPAN, ts);
  endtask

  // send one grid point; called at a falling edge
  task automatic send_point(logic [8:0] ring, logic [8:0] seg);
    if (in_idle_en && $urandom_range(0, 5) == 0)
      repeat ($urandom_range(1, 14)) @(negedge clk);
    ring_index = ring;
    seg_index = seg;
    in_valid = 1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_vertices.push_back(sphere_vertex(ring, seg));
    @(negedge clk);
    in_valid = 0;
  endtask

  task automatic drain;
    while (expected_vertices.size() != 0) @(negedge clk);
    repeat (LATENCY + 4) @(negedge clk);
  endtask

  // output stall bursts
  initial begin
    @(negedge clk);
    forever begin
      if (out_idle_en && $urandom_range(0, 5) == 0) begin
        out_stall = 1;
        repeat ($urandom_range(1, 14)) @(negedge clk);
        out_stall = 0;
      end
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    vertex_t e;
    if (!rst && out_valid && !out_stall) begin
      if (expected_vertices.size() == 0) begin
        $error("output beat with nothing expected");
        errors++;
      end else begin
        e = expected_vertices.pop_front();
        if (pos_x !== e.px) begin $error("pos_x exp %0h got %0h", e.px, pos_x); errors++; end
        if (pos_y !== e.py) begin $error("pos_y exp %0h got %0h", e.py, pos_y); errors++; end
        if (pos_z !== e.pz) begin $error("pos_z exp %0h got %0h", e.pz, pos_z); errors++; end
        if (norm_x !== e.nx) begin $error("norm_x exp %0h got %0h", e.nx, norm_x); errors++; end
        if (norm_y !== e.ny) begin $error("norm_y exp %0h got %0h", e.ny, norm_y); errors++; end
        if (norm_z !== e.nz) begin $error("norm_z exp %0h got %0h", e.nz, norm_z); errors++; end
        if (tex_u !== e.u) begin $error("tex_u exp %0h got %0h", e.u, tex_u); errors++; end
        if (tex_v !== e.v) begin $error("tex_v exp %0h got %0h", e.v, tex_v); errors++; end
        if (quad_base !== e.base) begin
          $error("quad_base exp %0h got %0h", e.base, quad_base); errors++;
        end
        if (quad_valid !== e.qv) begin
          $error("quad_valid exp %0b got %0b", e.qv, quad_valid); errors++;
        end
        if (top_line !== e.tl) begin
          $error("top_line exp %0b got %0b", e.tl, top_line); errors++;
        end
      end
    end
  end

  // watchdog on cycles without any accepted beat
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic test_defaults;
    for (int r = 0; r <= 2; r++)
      for (int s = 0; s <= 2; s++) send_point(9'(r * 8), 9'(s * 16));
    send_point(9'd16, 9'd32);
    send_point(9'h1FF, 9'h1FF);
    send_point(9'd15, 9'd31);
    drain();
  endtask

  task automatic test_extremes;
    // zero radius, zero counts, oversized spans
    configure(0, 0, 0, 16'hFFFF, 17'h1FFFF, 16'hFFFF, 17'h1FFFF);
    send_point(9'd0, 9'd0); send_point(9'd1, 9'd1); send_point(9'h1FF, 9'h0AA);
    drain();
    configure(16'hFFFF, 256, 256, 0, 65536, 0, 65536);
    send_point(9'd0, 9'd0); send_point(9'd256, 9'd256); send_point(9'd255, 9'd255);
    send_point(9'd128, 9'd64); send_point(9'h155, 9'h0AA); send_point(9'd64, 9'd192);
    drain();
    configure(256, 9'h1FF, 9'h1FF, 0, 0, 0, 0);
    send_point(9'd3, 9'd7); send_point(9'd256, 9'd0);
    drain();
  endtask

  task automatic test_random_phase(int n);
    longint w, h;
    configure($urandom_range(0, 65535), $urandom_range(0, 511), $urandom_range(0, 511),
              $urandom_range(0, 65535), $urandom_range(0, 131071),
              $urandom_range(0, 65535), $urandom_range(0, 131071));
    w = clip(wcnt, 1, MAX_SEG);
    h = clip(hcnt, 1, MAX_SEG);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 7) == 0)
        send_point(9'($urandom), 9'($urandom));
      else
        send_point(9'($urandom_range(0, h)), 9'($urandom_range(0, w)));
    end
    drain();
  endtask

  initial begin
    radius = 256; wcnt = 32; hcnt = 16; pbeg = 0; pspan = 65536; tbeg = 0; tspan = 32768;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 0;
    test_defaults();
    test_extremes();
    for (int p = 0; p < 12; p++) test_random_phase(140);
    in_idle_en = 0;
    out_idle_en = 0;
    test_random_phase(247);
    if (errors == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end
endmodule
